// ----- src/qbd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbd_pkg
// Shared widths, register codes, reset values and types of the QPSK burst
// demodulator.
// ----------------------------------------------------------------------------
package qbd_pkg;

	localparam int unsigned SAMPLE_W    = 12;
	localparam int unsigned DIFF_W      = SAMPLE_W + 1;
	localparam int unsigned SUM_W       = 36;
	localparam int unsigned THRESH_W    = 12;
	localparam int unsigned RUN_W       = 8;
	localparam int unsigned OFFSET_W    = 12;
	localparam int unsigned CFG_DATA_W  = 12;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned SYM_W       = 2;

	localparam logic [THRESH_W-1:0] RESET_LOW_THRESHOLD = THRESH_W'(200);
	localparam logic [RUN_W-1:0]    RESET_MIN_ZERO_RUN  = RUN_W'(100);
	localparam logic [OFFSET_W-1:0] RESET_DC_OFFSET     = OFFSET_W'(1300);

	localparam int unsigned DEF_SAMPLES_PER_SYMBOL  = 35;
	localparam int unsigned DEF_SYMBOLS_PER_MESSAGE = 4;
	localparam int unsigned DEF_PAYLOAD_DELAY       = 132;
	localparam int unsigned DEF_MESSAGE_SPAN        = 264;
	localparam int unsigned DEF_CARRIER_WIDTH       = 16;

	// 40 kHz carrier over a 100 us payload
	localparam int unsigned CARRIER_CYCLES = 4;
	localparam logic [63:0] ONE_Q30        = 64'h0000_0000_4000_0000;
	localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LOW_THRESHOLD = 2'd0,
		REG_MIN_ZERO_RUN  = 2'd1,
		REG_DC_OFFSET     = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_HUNT,
		MODE_DELAY,
		MODE_PAYLOAD,
		MODE_SPAN
	} mode_t;

	// per-sample position flags that travel with a payload sample
	typedef struct packed {
		logic             first;
		logic             eos;
		logic             last;
		logic [SYM_W-1:0] sym;
	} sym_tag_t;

endpackage

// ----- src/qbd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbd_ctrl
// Configuration registers, preamble search and burst sequencing; removes the
// DC offset and registers each payload sample with its table index and tags.
// ----------------------------------------------------------------------------
module qbd_ctrl import qbd_pkg::*; #(
	parameter int unsigned SAMPLES_PER_SYMBOL  = DEF_SAMPLES_PER_SYMBOL,
	parameter int unsigned SYMBOLS_PER_MESSAGE = DEF_SYMBOLS_PER_MESSAGE,
	parameter int unsigned PAYLOAD_DELAY       = DEF_PAYLOAD_DELAY,
	parameter int unsigned MESSAGE_SPAN        = DEF_MESSAGE_SPAN
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [CFG_INDEX_W-1:0]               cfg_index,
	input  logic [CFG_DATA_W-1:0]                cfg_data,
	input  logic                                 in_valid,
	input  logic [SAMPLE_W-1:0]                  sample,
	input  logic                                 adv,
	output logic                                 v_s1,
	output logic signed [DIFF_W-1:0]             diff_s1,
	output logic [$clog2(SAMPLES_PER_SYMBOL*SYMBOLS_PER_MESSAGE)-1:0] idx_s1,
	output sym_tag_t                             tag_s1
);

	localparam int unsigned PayloadLen = SAMPLES_PER_SYMBOL * SYMBOLS_PER_MESSAGE;
	localparam int unsigned IdxW       = $clog2(PayloadLen);
	localparam int unsigned JW         = $clog2(SAMPLES_PER_SYMBOL);
	localparam int unsigned PosMaxA    = PAYLOAD_DELAY + PayloadLen;
	localparam int unsigned PosMaxB    = (MESSAGE_SPAN > 256) ? MESSAGE_SPAN : 256;
	localparam int unsigned PosMax     = (PosMaxA > PosMaxB) ? PosMaxA : PosMaxB;
	localparam int unsigned PosW       = $clog2(PosMax + 2);

	logic [THRESH_W-1:0] thr_q;
	logic [RUN_W-1:0]    mzr_q;
	logic [OFFSET_W-1:0] dc_q;

	mode_t            mode_q, mode_d;
	logic [RUN_W-1:0] sc_q, sc_d;
	logic [PosW-1:0]  pos_q, pos_d;
	logic [JW-1:0]    j_q, j_d;
	logic [SYM_W-1:0] sym_q, sym_d;

	logic            take;
	logic            silent;
	logic            pay;
	logic [IdxW-1:0] idx_d;
	sym_tag_t        tag_d;

	assign take   = in_valid & adv;
	assign silent = (sample < thr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= RESET_LOW_THRESHOLD;
			mzr_q <= RESET_MIN_ZERO_RUN;
			dc_q  <= RESET_DC_OFFSET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOW_THRESHOLD: thr_q <= cfg_data[THRESH_W-1:0];
				REG_MIN_ZERO_RUN:  mzr_q <= cfg_data[RUN_W-1:0];
				REG_DC_OFFSET:     dc_q  <= cfg_data[OFFSET_W-1:0];
				default:           ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HUNT;
			sc_q   <= '0;
			pos_q  <= '0;
			j_q    <= '0;
			sym_q  <= '0;
			v_s1   <= 1'b0;
		end else if (adv) begin
			mode_q <= mode_d;
			sc_q   <= sc_d;
			pos_q  <= pos_d;
			j_q    <= j_d;
			sym_q  <= sym_d;
			v_s1   <= pay;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s1 <= $signed({1'b0, sample}) - $signed({1'b0, dc_q});
			idx_s1  <= idx_d;
			tag_s1  <= tag_d;
		end
	end

	always_comb begin
		mode_d = mode_q;
		sc_d   = sc_q;
		pos_d  = pos_q;
		j_d    = j_q;
		sym_d  = sym_q;
		pay    = 1'b0;
		idx_d  = '0;
		tag_d  = '0;
		if (take) begin
			unique case (mode_q) inside
				MODE_HUNT: begin
					if (silent) begin
						if (sc_q >= mzr_q) begin
							// offset of this sample from the start of the run
							pos_d  = PosW'(sc_q);
							sc_d   = '0;
							mode_d = MODE_DELAY;
						end else begin
							sc_d = sc_q + RUN_W'(1);
						end
					end else begin
						sc_d = '0;
					end
				end
				MODE_DELAY, MODE_SPAN: pos_d = pos_q + PosW'(1);
				default: ;
			endcase

			// a long preamble may start the payload on this very sample
			if (mode_d == MODE_DELAY && pos_d >= PosW'(PAYLOAD_DELAY)) begin
				mode_d = MODE_PAYLOAD;
				pos_d  = '0;
				j_d    = '0;
				sym_d  = '0;
			end

			if (mode_d == MODE_PAYLOAD) begin
				pay        = 1'b1;
				idx_d      = pos_d[IdxW-1:0];
				tag_d.first = (j_d == '0);
				tag_d.eos   = (j_d == JW'(SAMPLES_PER_SYMBOL - 1));
				tag_d.last  = (pos_d == PosW'(PayloadLen - 1));
				tag_d.sym   = sym_d;
				j_d   = tag_d.eos ? '0 : j_d + JW'(1);
				sym_d = tag_d.eos ? sym_d + SYM_W'(1) : sym_d;
				if (tag_d.last) begin
					// span wait is timed from the nominal start of the silent run
					mode_d = MODE_SPAN;
					pos_d  = PosW'(PAYLOAD_DELAY + PayloadLen - 1);
				end else begin
					pos_d = pos_d + PosW'(1);
				end
			end

			if (mode_d == MODE_SPAN && (pos_d + PosW'(1)) >= PosW'(MESSAGE_SPAN)) begin
				mode_d = MODE_HUNT;
				sc_d   = '0;
			end
		end
	end

	a_pos_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_PAYLOAD) |-> (pos_q < PosW'(PayloadLen)))
		else $error("payload position beyond carrier table");

	a_phase_in_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_PAYLOAD) |-> (j_q <= JW'(SAMPLES_PER_SYMBOL - 1)))
		else $error("symbol phase counter out of range");

	a_burst_ends_on_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		(take && mode_q == MODE_PAYLOAD && mode_d != MODE_PAYLOAD)
		|-> (j_q == JW'(SAMPLES_PER_SYMBOL - 1) && pos_q == PosW'(PayloadLen - 1)))
		else $error("burst left payload mode in mid symbol");

endmodule

// ----- src/qbd_mixer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbd_mixer
// Fixed cosine/sine carrier table and the two carrier multipliers; registers
// the in-phase and quadrature products of each payload sample.
// ----------------------------------------------------------------------------
module qbd_mixer import qbd_pkg::*; #(
	parameter int unsigned SAMPLES_PER_SYMBOL  = DEF_SAMPLES_PER_SYMBOL,
	parameter int unsigned SYMBOLS_PER_MESSAGE = DEF_SYMBOLS_PER_MESSAGE,
	parameter int unsigned CARRIER_WIDTH       = DEF_CARRIER_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic                                 v_s1,
	input  logic signed [DIFF_W-1:0]             diff_s1,
	input  logic [$clog2(SAMPLES_PER_SYMBOL*SYMBOLS_PER_MESSAGE)-1:0] idx_s1,
	input  sym_tag_t                             tag_s1,
	output logic                                 v_s2,
	output logic signed [DIFF_W+CARRIER_WIDTH-1:0] pi_s2,
	output logic signed [DIFF_W+CARRIER_WIDTH-1:0] pq_s2,
	output sym_tag_t                             tag_s2
);

	localparam int unsigned PayloadLen = SAMPLES_PER_SYMBOL * SYMBOLS_PER_MESSAGE;
	localparam int unsigned ProdW      = DIFF_W + CARRIER_WIDTH;
	localparam logic [63:0] Den        = 64'(PayloadLen - 1);
	localparam int unsigned QShift     = 30 - (CARRIER_WIDTH - 1);
	localparam longint      QRound     = longint'(64'd1 << (QShift - 1));
	localparam longint      QTop       = longint'((64'd1 << (CARRIER_WIDTH - 1)) - 64'd1);

	// round a Q30 value in [0, 1] to Q1.(CARRIER_WIDTH-1), saturating +1.0
	function automatic logic signed [CARRIER_WIDTH-1:0] quantize(input longint v);
		longint r;
		r = (v + QRound) >>> QShift;
		if (r > QTop) r = QTop;
		return CARRIER_WIDTH'(r);
	endfunction

	// cos and sin of entry p by a Q30 Taylor series, folded by quadrant
	function automatic logic [2*CARRIER_WIDTH-1:0] carrier_entry(input int unsigned p);
		logic [63:0] m, q, r, a, a2, ts, tc;
		longint ss, cs;
		logic signed [CARRIER_WIDTH-1:0] sq, cq, cos_v, sin_v;
		m  = (64'(CARRIER_CYCLES) * 64'(p)) % Den;
		q  = (64'd4 * m) / Den;
		r  = 64'd4 * m - q * Den;
		a  = (HALF_PI_Q30 * r) / Den;
		a2 = (a * a) >> 30;
		ts = a;
		tc = ONE_Q30;
		ss = longint'(a);
		cs = longint'(ONE_Q30);
		ts = ((ts * a2) >> 30) / 64'd6;   tc = ((tc * a2) >> 30) / 64'd2;
		ss = ss - longint'(ts);           cs = cs - longint'(tc);
		ts = ((ts * a2) >> 30) / 64'd20;  tc = ((tc * a2) >> 30) / 64'd12;
		ss = ss + longint'(ts);           cs = cs + longint'(tc);
		ts = ((ts * a2) >> 30) / 64'd42;  tc = ((tc * a2) >> 30) / 64'd30;
		ss = ss - longint'(ts);           cs = cs - longint'(tc);
		ts = ((ts * a2) >> 30) / 64'd72;  tc = ((tc * a2) >> 30) / 64'd56;
		ss = ss + longint'(ts);           cs = cs + longint'(tc);
		ts = ((ts * a2) >> 30) / 64'd110; tc = ((tc * a2) >> 30) / 64'd90;
		ss = ss - longint'(ts);           cs = cs - longint'(tc);
		ts = ((ts * a2) >> 30) / 64'd156; tc = ((tc * a2) >> 30) / 64'd132;
		ss = ss + longint'(ts);           cs = cs + longint'(tc);
		ts = ((ts * a2) >> 30) / 64'd210; tc = ((tc * a2) >> 30) / 64'd182;
		ss = ss - longint'(ts);           cs = cs - longint'(tc);
		ts = ((ts * a2) >> 30) / 64'd272; tc = ((tc * a2) >> 30) / 64'd240;
		ss = ss + longint'(ts);           cs = cs + longint'(tc);
		if (ss < 0) ss = 0;
		if (ss > longint'(ONE_Q30)) ss = longint'(ONE_Q30);
		if (cs < 0) cs = 0;
		if (cs > longint'(ONE_Q30)) cs = longint'(ONE_Q30);
		sq = quantize(ss);
		cq = quantize(cs);
		case (q)
			64'd0: begin
				cos_v = cq;
				sin_v = sq;
			end
			64'd1: begin
				cos_v = -sq;
				sin_v = cq;
			end
			64'd2: begin
				cos_v = -cq;
				sin_v = -sq;
			end
			default: begin
				cos_v = sq;
				sin_v = -cq;
			end
		endcase
		return {cos_v, sin_v};
	endfunction

	logic signed [CARRIER_WIDTH-1:0] cos_rom [PayloadLen];
	logic signed [CARRIER_WIDTH-1:0] sin_rom [PayloadLen];

	for (genvar gp = 0; gp < PayloadLen; gp++) begin : g_rom
		localparam logic [2*CARRIER_WIDTH-1:0] Entry = carrier_entry(gp);
		assign cos_rom[gp] = Entry[2*CARRIER_WIDTH-1:CARRIER_WIDTH];
		assign sin_rom[gp] = Entry[CARRIER_WIDTH-1:0];
	end

	logic signed [ProdW-1:0] pi_d, pq_d;

	assign pi_d = ProdW'(diff_s1) * ProdW'(cos_rom[idx_s1]);
	assign pq_d = ProdW'(diff_s1) * ProdW'(sin_rom[idx_s1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pi_s2  <= pi_d;
			pq_s2  <= pq_d;
			tag_s2 <= tag_s1;
		end
	end

endmodule

// ----- src/qbd_integrator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbd_integrator
// Trapezoid accumulation of the products over each symbol with saturation,
// and the result register that holds a decided symbol until it is taken.
// ----------------------------------------------------------------------------
module qbd_integrator import qbd_pkg::*; #(
	parameter int unsigned CARRIER_WIDTH = DEF_CARRIER_WIDTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   v_s2,
	input  logic signed [DIFF_W+CARRIER_WIDTH-1:0] pi_s2,
	input  logic signed [DIFF_W+CARRIER_WIDTH-1:0] pq_s2,
	input  sym_tag_t                               tag_s2,
	output logic                                   adv,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [1:0]                             symbol_bits,
	output logic [SYM_W-1:0]                       symbol_index,
	output logic signed [SUM_W-1:0]                in_phase_sum,
	output logic signed [SUM_W-1:0]                quadrature_sum,
	output logic                                   last_symbol
);

	localparam int unsigned ProdW   = DIFF_W + CARRIER_WIDTH;
	localparam int unsigned SumExtW = ((SUM_W > ProdW) ? SUM_W : ProdW) + 2;
	localparam logic signed [SumExtW-1:0] SumMaxExt =
		SumExtW'({1'b0, {(SUM_W-1){1'b1}}});
	localparam logic signed [SumExtW-1:0] SumMinExt = ~SumMaxExt;

	function automatic logic signed [SUM_W-1:0] sat(input logic signed [SumExtW-1:0] v);
		if (v > SumMaxExt) return SUM_W'(SumMaxExt);
		if (v < SumMinExt) return SUM_W'(SumMinExt);
		return SUM_W'(v);
	endfunction

	logic signed [SUM_W-1:0] acc_i_q, acc_q_q;
	logic signed [ProdW-1:0] prev_i_q, prev_q_q;
	logic signed [SUM_W-1:0] acc_i_d, acc_q_d;
	logic                    out_valid_q;
	logic [SYM_W-1:0]        sym_q;
	logic signed [SUM_W-1:0] isum_q, qsum_q;
	logic                    last_q;
	logic                    blocked;
	logic                    load;

	// freeze the whole pipe only when a finished symbol meets a full, stalled result
	assign blocked = v_s2 & tag_s2.eos & out_valid_q & out_stall;
	assign adv     = ~blocked;
	assign load    = adv & v_s2 & tag_s2.eos;

	always_comb begin
		if (tag_s2.first) begin
			acc_i_d = '0;
			acc_q_d = '0;
		end else begin
			acc_i_d = sat(SumExtW'(acc_i_q) + SumExtW'(prev_i_q) + SumExtW'(pi_s2));
			acc_q_d = sat(SumExtW'(acc_q_q) + SumExtW'(prev_q_q) + SumExtW'(pq_s2));
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			acc_i_q  <= acc_i_d;
			acc_q_q  <= acc_q_d;
			prev_i_q <= pi_s2;
			prev_q_q <= pq_s2;
		end
		if (load) begin
			isum_q <= acc_i_d;
			qsum_q <= acc_q_d;
			sym_q  <= tag_s2.sym;
			last_q <= tag_s2.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// a zero sum decides as negative
	assign symbol_bits    = {qsum_q > SUM_W'(0), isum_q > SUM_W'(0)};
	assign out_valid      = out_valid_q;
	assign symbol_index   = sym_q;
	assign in_phase_sum   = isum_q;
	assign quadrature_sum = qsum_q;
	assign last_symbol    = last_q;

	a_hold_acc_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		blocked |=> ($stable(acc_i_q) && $stable(acc_q_q) && $stable(prev_i_q)))
		else $error("accumulator moved while pipe was frozen");

	a_symbol_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s2 && tag_s2.first) |=> (acc_i_q == '0 && acc_q_q == '0))
		else $error("accumulator not cleared at symbol start");

endmodule

// ----- src/qpsk_burst_demodulator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpsk_burst_demodulator_unit
// Burst QPSK integrate-and-dump demodulator: preamble search on a silent run,
// carrier mixing of the payload, trapezoid integration and sign decision.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle; requests are stalled only while a decided
// symbol waits in the result register and the next symbol completes.
// Path: a symbol's last sample passes the sample register, the product register
// and the result register in that order before its result is presented.
// Reset: arst_n clears the sequencer, the valid bits and restores the register
// defaults; the carrier table is constant logic and needs no clearing pass.
module qpsk_burst_demodulator_unit import qbd_pkg::*; #(
	parameter int unsigned SAMPLES_PER_SYMBOL  = DEF_SAMPLES_PER_SYMBOL,
	parameter int unsigned SYMBOLS_PER_MESSAGE = DEF_SYMBOLS_PER_MESSAGE,
	parameter int unsigned PAYLOAD_DELAY       = DEF_PAYLOAD_DELAY,
	parameter int unsigned MESSAGE_SPAN        = DEF_MESSAGE_SPAN,
	parameter int unsigned CARRIER_WIDTH       = DEF_CARRIER_WIDTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_INDEX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [SAMPLE_W-1:0]     sample,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              symbol_bits,
	output logic [SYM_W-1:0]        symbol_index,
	output logic signed [SUM_W-1:0] in_phase_sum,
	output logic signed [SUM_W-1:0] quadrature_sum,
	output logic                    last_symbol
);

	localparam int unsigned PayloadLen = SAMPLES_PER_SYMBOL * SYMBOLS_PER_MESSAGE;
	localparam int unsigned IdxW       = $clog2(PayloadLen);
	localparam int unsigned ProdW      = DIFF_W + CARRIER_WIDTH;

	logic                    adv;
	logic                    v_s1, v_s2;
	logic signed [DIFF_W-1:0] diff_s1;
	logic [IdxW-1:0]         idx_s1;
	sym_tag_t                tag_s1, tag_s2;
	logic signed [ProdW-1:0] pi_s2, pq_s2;

	assign in_stall = ~adv;

	qbd_ctrl #(
		.SAMPLES_PER_SYMBOL  (SAMPLES_PER_SYMBOL),
		.SYMBOLS_PER_MESSAGE (SYMBOLS_PER_MESSAGE),
		.PAYLOAD_DELAY       (PAYLOAD_DELAY),
		.MESSAGE_SPAN        (MESSAGE_SPAN)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.sample    (sample),
		.adv       (adv),
		.v_s1      (v_s1),
		.diff_s1   (diff_s1),
		.idx_s1    (idx_s1),
		.tag_s1    (tag_s1)
	);

	qbd_mixer #(
		.SAMPLES_PER_SYMBOL  (SAMPLES_PER_SYMBOL),
		.SYMBOLS_PER_MESSAGE (SYMBOLS_PER_MESSAGE),
		.CARRIER_WIDTH       (CARRIER_WIDTH)
	) u_mixer (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.v_s1    (v_s1),
		.diff_s1 (diff_s1),
		.idx_s1  (idx_s1),
		.tag_s1  (tag_s1),
		.v_s2    (v_s2),
		.pi_s2   (pi_s2),
		.pq_s2   (pq_s2),
		.tag_s2  (tag_s2)
	);

	qbd_integrator #(
		.CARRIER_WIDTH (CARRIER_WIDTH)
	) u_integrator (
		.clk            (clk),
		.arst_n         (arst_n),
		.v_s2           (v_s2),
		.pi_s2          (pi_s2),
		.pq_s2          (pq_s2),
		.tag_s2         (tag_s2),
		.adv            (adv),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.symbol_bits    (symbol_bits),
		.symbol_index   (symbol_index),
		.in_phase_sum   (in_phase_sum),
		.quadrature_sum (quadrature_sum),
		.last_symbol    (last_symbol)
	);

endmodule
